[sv/urd_pkg.sv]
`timescale 1ns / 1ps
// shared widths, constants and reciprocal seed table of the perspective divider
package urd_pkg;

    localparam int DepthW = 16;
    localparam int QuotW  = 17;
    localparam int IdxW   = 9;
    localparam int SeedW  = 10;
    localparam int NumW   = 17;
    localparam int R1W    = 17;
    localparam int R2W    = 18;

    localparam logic [SeedW-1:0] SEED_BIAS = 10'h101;
    localparam logic [25:0]      NR_TWO    = 26'h2000080;
    localparam logic [26:0]      NR_RND    = 27'h0000080;
    localparam logic [35:0]      Q_RND     = 36'h000008000;
    localparam logic [15:0]      IDX_RND   = 16'h0040;
    localparam logic [QuotW-1:0] QUOT_MAX  = 17'h1FFFF;

    typedef struct packed {
        logic              ovf;
        logic [DepthW-1:0] d;
        logic [NumW-1:0]   n;
        logic [IdxW-1:0]   idx;
    } s1_t;

    typedef struct packed {
        logic             ovf;
        logic [R1W-1:0]   r1;
        logic [SeedW-1:0] u;
        logic [NumW-1:0]  n;
    } s2_t;

    typedef struct packed {
        logic            ovf;
        logic [R2W-1:0]  r2;
        logic [NumW-1:0] n;
    } s3_t;

    localparam logic [7:0] RECIP_ROM [0:256] = '{
        8'hff, 8'hfd, 8'hfb, 8'hf9, 8'hf7, 8'hf5, 8'hf3, 8'hf1,
        8'hef, 8'hee, 8'hec, 8'hea, 8'he8, 8'he6, 8'he4, 8'he3,
        8'he1, 8'hdf, 8'hdd, 8'hdc, 8'hda, 8'hd8, 8'hd6, 8'hd5,
        8'hd3, 8'hd1, 8'hd0, 8'hce, 8'hcd, 8'hcb, 8'hc9, 8'hc8,
        8'hc6, 8'hc5, 8'hc3, 8'hc1, 8'hc0, 8'hbe, 8'hbd, 8'hbb,
        8'hba, 8'hb8, 8'hb7, 8'hb5, 8'hb4, 8'hb2, 8'hb1, 8'hb0,
        8'hae, 8'had, 8'hab, 8'haa, 8'ha9, 8'ha7, 8'ha6, 8'ha4,
        8'ha3, 8'ha2, 8'ha0, 8'h9f, 8'h9e, 8'h9c, 8'h9b, 8'h9a,
        8'h99, 8'h97, 8'h96, 8'h95, 8'h94, 8'h92, 8'h91, 8'h90,
        8'h8f, 8'h8d, 8'h8c, 8'h8b, 8'h8a, 8'h89, 8'h87, 8'h86,
        8'h85, 8'h84, 8'h83, 8'h82, 8'h81, 8'h7f, 8'h7e, 8'h7d,
        8'h7c, 8'h7b, 8'h7a, 8'h79, 8'h78, 8'h77, 8'h75, 8'h74,
        8'h73, 8'h72, 8'h71, 8'h70, 8'h6f, 8'h6e, 8'h6d, 8'h6c,
        8'h6b, 8'h6a, 8'h69, 8'h68, 8'h67, 8'h66, 8'h65, 8'h64,
        8'h63, 8'h62, 8'h61, 8'h60, 8'h5f, 8'h5e, 8'h5d, 8'h5d,
        8'h5c, 8'h5b, 8'h5a, 8'h59, 8'h58, 8'h57, 8'h56, 8'h55,
        8'h54, 8'h53, 8'h53, 8'h52, 8'h51, 8'h50, 8'h4f, 8'h4e,
        8'h4d, 8'h4d, 8'h4c, 8'h4b, 8'h4a, 8'h49, 8'h48, 8'h48,
        8'h47, 8'h46, 8'h45, 8'h44, 8'h43, 8'h43, 8'h42, 8'h41,
        8'h40, 8'h3f, 8'h3f, 8'h3e, 8'h3d, 8'h3c, 8'h3c, 8'h3b,
        8'h3a, 8'h39, 8'h39, 8'h38, 8'h37, 8'h36, 8'h36, 8'h35,
        8'h34, 8'h33, 8'h33, 8'h32, 8'h31, 8'h31, 8'h30, 8'h2f,
        8'h2e, 8'h2e, 8'h2d, 8'h2c, 8'h2c, 8'h2b, 8'h2a, 8'h2a,
        8'h29, 8'h28, 8'h28, 8'h27, 8'h26, 8'h26, 8'h25, 8'h24,
        8'h24, 8'h23, 8'h22, 8'h22, 8'h21, 8'h20, 8'h20, 8'h1f,
        8'h1e, 8'h1e, 8'h1d, 8'h1d, 8'h1c, 8'h1b, 8'h1b, 8'h1a,
        8'h19, 8'h19, 8'h18, 8'h18, 8'h17, 8'h16, 8'h16, 8'h15,
        8'h15, 8'h14, 8'h14, 8'h13, 8'h12, 8'h12, 8'h11, 8'h11,
        8'h10, 8'h0f, 8'h0f, 8'h0e, 8'h0e, 8'h0d, 8'h0d, 8'h0c,
        8'h0c, 8'h0b, 8'h0a, 8'h0a, 8'h09, 8'h09, 8'h08, 8'h08,
        8'h07, 8'h07, 8'h06, 8'h06, 8'h05, 8'h05, 8'h04, 8'h04,
        8'h03, 8'h03, 8'h02, 8'h02, 8'h01, 8'h01, 8'h00, 8'h00,
        8'h00
    };

    // leading zeros of a 16-bit value, 15 for values of 0 or 1
    function automatic logic [3:0] lead_zeros(input logic [DepthW-1:0] v);
        logic [3:0] n;
        logic       found;
        n     = 4'd15;
        found = 1'b0;
        for (int i = DepthW - 1; i >= 1; i--)
        begin
            if (!found && v[i])
            begin
                n     = 4'(DepthW - 1 - i);
                found = 1'b1;
            end
        end
        return n;
    endfunction

endpackage

[sv/unr_table_reciprocal_divide.sv]
`timescale 1ns / 1ps
// perspective divider: seed table, two newton-raphson steps, final multiply
// the result strobe comes from the last of four register stages after the accepting edge
// throughput: one item per clock, busy stays low; each stage holds one item
// configuration writes are taken in any cycle (ready held high)
// reset: asynchronous, clears the distance register and all stage valid bits
// the receiver cannot stall, so stage registers advance every cycle
module unr_table_reciprocal_divide (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [urd_pkg::DepthW-1:0]  depth,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [urd_pkg::DepthW-1:0]  proj_distance,
    output logic                        done,
    output logic [urd_pkg::QuotW-1:0]   quotient,
    output logic                        div_overflow
);
    import urd_pkg::*;

    logic [DepthW-1:0] dist_reg;
    logic              v1_reg, v2_reg, v3_reg, vo_reg;
    s1_t               s1_reg, s1_next;
    s2_t               s2_reg, s2_next;
    s3_t               s3_reg, s3_next;
    logic [QuotW-1:0]  quot_reg, quot_next;
    logic              ovf_reg;

    logic [3:0]        lz;
    logic [31:0]       n_wide;
    logic [15:0]       idx_sum;
    logic [SeedW-1:0]  u;
    logic [25:0]       du;
    logic [25:0]       r1_diff;
    logic [26:0]       r1u;
    logic [26:0]       r2_sum;
    logic [34:0]       rn;
    logic [35:0]       q_sum;
    logic [19:0]       q_full;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // stage 1: overflow test, normalize, table index
    always_comb
    begin
        lz          = lead_zeros(depth);
        s1_next.ovf = ({depth, 1'b0} <= {1'b0, dist_reg});
        s1_next.d   = depth << lz;
        n_wide      = {16'd0, dist_reg} << lz;
        s1_next.n   = n_wide[NumW-1:0];
        idx_sum     = {1'b0, s1_next.d[DepthW-2:0]} + IDX_RND;
        s1_next.idx = idx_sum[15:7];
    end

    // stage 2: seed and first refinement
    always_comb
    begin
        u           = {2'b00, RECIP_ROM[s1_reg.idx]} + SEED_BIAS;
        du          = 26'(s1_reg.d * u);
        r1_diff     = NR_TWO - du;
        s2_next.ovf = s1_reg.ovf;
        s2_next.r1  = r1_diff[24:8];
        s2_next.u   = u;
        s2_next.n   = s1_reg.n;
    end

    // stage 3: second refinement
    always_comb
    begin
        r1u         = 27'(s2_reg.r1 * s2_reg.u);
        r2_sum      = r1u + NR_RND;
        s3_next.ovf = s2_reg.ovf;
        s3_next.r2  = r2_sum[25:8];
        s3_next.n   = s2_reg.n;
    end

    // stage 4: multiply by distance, round, clamp
    always_comb
    begin
        rn     = 35'(s3_reg.r2 * s3_reg.n);
        q_sum  = {1'b0, rn} + Q_RND;
        q_full = q_sum[35:16];
        if (s3_reg.ovf || (q_full[19:17] != 3'b000))
        begin
            quot_next = QUOT_MAX;
        end
        else
        begin
            quot_next = q_full[QuotW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dist_reg <= '0;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            vo_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                dist_reg <= proj_distance;
            end
            v1_reg <= start && !busy;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            vo_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg   <= s1_next;
        s2_reg   <= s2_next;
        s3_reg   <= s3_next;
        quot_reg <= quot_next;
        ovf_reg  <= s3_reg.ovf;
    end

    assign done         = vo_reg;
    assign quotient     = quot_reg;
    assign div_overflow = ovf_reg;

endmodule

[sv/urd_checker.sv]
`timescale 1ns / 1ps
// port-level checks of the perspective divider, bound to the top level
module urd_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        start,
    input logic                        busy,
    input logic [urd_pkg::DepthW-1:0]  depth,
    input logic                        done,
    input logic [urd_pkg::QuotW-1:0]   quotient,
    input logic                        div_overflow
);
    import urd_pkg::*;

    // every accepted item later comes out as a result
    a_item_out: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##4 done)
        else $error("accepted item produced no result");

    // no result without an earlier accepted item
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 4))
        else $error("result without accepted item");

    // overflow forces the saturated quotient
    a_ovf_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (done && div_overflow) |-> (quotient == QUOT_MAX))
        else $error("overflow without saturated quotient");

    // zero depth always overflows
    a_zero_depth: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (depth == '0)) |-> ##4 (done && div_overflow))
        else $error("zero depth did not overflow");

endmodule

bind unr_table_reciprocal_divide urd_checker u_urd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .depth        (depth),
    .done         (done),
    .quotient     (quotient),
    .div_overflow (div_overflow)
);

[tb/div_result_checker.sv]
`timescale 1ns / 1ps
// checker for the perspective divider: predicts each quotient and compares it with the result
module div_result_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic                       busy,
    input  logic [urd_pkg::DepthW-1:0] depth,
    input  logic                       cfg_valid,
    input  logic                       cfg_ready,
    input  logic [urd_pkg::DepthW-1:0] proj_distance,
    input  logic                       done,
    input  logic [urd_pkg::QuotW-1:0]  quotient,
    input  logic                       div_overflow,
    output int                         fail_count,
    output int                         pending
);

    typedef struct {
        logic [urd_pkg::DepthW-1:0] depth;
        logic [urd_pkg::QuotW-1:0]  quot;
        logic                       ovf;
    } quot_rec_t;

    logic [urd_pkg::DepthW-1:0] distance;
    quot_rec_t                  quot_expected[$];

    function automatic quot_rec_t predict_quotient(input logic [urd_pkg::DepthW-1:0] dep,
                                                   input logic [urd_pkg::DepthW-1:0] dist_val);
        quot_rec_t                  res;
        logic [urd_pkg::DepthW-1:0] v;
        int                         z;
        logic [63:0]                num;
        logic [63:0]                den;
        logic [63:0]                idx;
        logic [63:0]                seed;
        logic [63:0]                r;
        logic [63:0]                q;
        res.depth = dep;
        if (64'(dep) * 64'd2 <= 64'(dist_val))
        begin
            res.quot = urd_pkg::QUOT_MAX;
            res.ovf  = 1'b1;
        end
        else
        begin
            v = dep;
            z = 0;
            while (z < 15 && !v[urd_pkg::DepthW-1])
            begin
                v = v << 1;
                z++;
            end
            num  = 64'(dist_val) << z;
            den  = (64'(dep) << z) & 64'hFFFF;
            idx  = ((den & 64'h7FFF) + 64'h40) >> 7;
            seed = 64'(urd_pkg::RECIP_ROM[idx[8:0]]) + 64'h101;
            r    = (64'h2000080 - den * seed) >> 8;
            r    = (64'h0000080 + r * seed) >> 8;
            q    = (64'h0008000 + r * num) >> 16;
            if (q > 64'h1FFFF)
                q = 64'h1FFFF;
            res.quot = q[urd_pkg::QuotW-1:0];
            res.ovf  = 1'b0;
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        quot_rec_t exp_rec;
        if (!rst_n)
        begin
            distance = '0;
            quot_expected.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            if (done)
            begin
                if (quot_expected.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result: quotient %h overflow %b",
                                 quotient, div_overflow);
                end
                else
                begin
                    exp_rec = quot_expected.pop_front();
                    if (quotient !== exp_rec.quot || div_overflow !== exp_rec.ovf)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"mismatch depth %h: quotient exp %h got %h, ",
                                      "overflow exp %b got %b"},
                                     exp_rec.depth, exp_rec.quot, quotient,
                                     exp_rec.ovf, div_overflow);
                    end
                end
            end
            if (start && !busy)
                quot_expected.push_back(predict_quotient(depth, distance));
            if (cfg_valid && cfg_ready)
                distance = proj_distance;
            pending = quot_expected.size();
        end
    end

endmodule

[tb/unr_table_reciprocal_divide_test.sv]
`timescale 1ns / 1ps
// testbench top of the perspective divider: stimulus, watchdog and verdict
module unr_table_reciprocal_divide_test;

    localparam int StallLimit = 1000;

    logic                       clk;
    logic                       rst_n;
    logic                       start;
    logic                       busy;
    logic [urd_pkg::DepthW-1:0] depth;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [urd_pkg::DepthW-1:0] proj_distance;
    logic                       done;
    logic [urd_pkg::QuotW-1:0]  quotient;
    logic                       div_overflow;
    int                         fail_count;
    int                         pending;
    int                         stall_cnt;

    unr_table_reciprocal_divide i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .depth         (depth),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .proj_distance (proj_distance),
        .done          (done),
        .quotient      (quotient),
        .div_overflow  (div_overflow)
    );

    div_result_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .depth         (depth),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .proj_distance (proj_distance),
        .done          (done),
        .quotient      (quotient),
        .div_overflow  (div_overflow),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || (cfg_valid && cfg_ready) || done)
            stall_cnt <= 0;
        else
            stall_cnt <= stall_cnt + 1;
        if (stall_cnt >= StallLimit)
        begin
            $display("FAIL unr_table_reciprocal_divide");
            $finish;
        end
    end

    // called at a falling edge, returns at a falling edge with start still high
    task automatic send_depth(input logic [urd_pkg::DepthW-1:0] value, input bit idle_on);
        while (idle_on && $urandom_range(0, 99) < 14)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        depth <= value;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    task automatic write_distance(input logic [urd_pkg::DepthW-1:0] value);
        drain();
        cfg_valid     <= 1'b1;
        proj_distance <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    function automatic logic [urd_pkg::DepthW-1:0] pick_depth(
            input logic [urd_pkg::DepthW-1:0] dist_val);
        int          sel;
        logic [15:0] r;
        sel = $urandom_range(0, 9);
        r   = 16'($urandom());
        if (sel <= 3)
            return r;
        else if (sel <= 6)
            return r & 16'((32'd1 << $urandom_range(1, 16)) - 1);
        else if (sel <= 8)
            // around the overflow boundary
            return 16'(int'(dist_val >> 1) + $urandom_range(0, 4) - 2);
        else
        begin
            case ($urandom_range(0, 3))
                0: return 16'h0000;
                1: return 16'h0001;
                2: return 16'h8000;
                default: return 16'hFFFF;
            endcase
        end
    endfunction

    initial
    begin
        logic [urd_pkg::DepthW-1:0] dist_val;
        rst_n         = 1'b0;
        start         = 1'b0;
        depth         = '0;
        cfg_valid     = 1'b0;
        proj_distance = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // distance still at its reset value
        send_depth(16'h0000, 1'b0);
        send_depth(16'h0001, 1'b0);
        send_depth(16'hFFFF, 1'b0);

        write_distance(16'h8000);
        send_depth(16'h0000, 1'b1);
        send_depth(16'h0001, 1'b1);
        send_depth(16'h3FFF, 1'b1);
        send_depth(16'h4000, 1'b1);
        send_depth(16'h4001, 1'b1);
        send_depth(16'h7FFF, 1'b1);
        send_depth(16'h8000, 1'b1);
        send_depth(16'hFFFF, 1'b1);
        send_depth(16'h00FF, 1'b1);
        send_depth(16'h0100, 1'b1);

        write_distance(16'hFFFF);
        send_depth(16'h7FFF, 1'b0);
        send_depth(16'h8000, 1'b0);
        send_depth(16'h8001, 1'b0);
        send_depth(16'hFFFF, 1'b0);
        send_depth(16'h0001, 1'b0);
        send_depth(16'hAAAA, 1'b0);

        write_distance(16'h0001);
        send_depth(16'h0000, 1'b1);
        send_depth(16'h0001, 1'b1);
        send_depth(16'h5555, 1'b1);

        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: dist_val = 16'hFFFF;
                1: dist_val = 16'h0000;
                2: dist_val = 16'h0001;
                default: dist_val = 16'($urandom());
            endcase
            write_distance(dist_val);
            for (int k = 0; k < 160; k++)
                send_depth(pick_depth(dist_val), ph != 3);
        end

        drain();
        if (fail_count == 0 && pending == 0)
            $display("PASS unr_table_reciprocal_divide");
        else
            $display("FAIL unr_table_reciprocal_divide");
        $finish;
    end

endmodule
